// ===== rtl/mp2w_pkg.sv =====
package mp2w_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CSR_W    = 11;
   localparam int ROW_W    = 10;
   localparam int ROWS_W   = 11;
   localparam int WIN_W    = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type SAMPLE_MIN = 16'h8000;

   localparam logic [ROWS_W-1:0] ROW_LIMIT  = 11'd1024;
   localparam logic [CSR_W-1:0]  ROWS_RESET = 11'd32;
   localparam logic [CSR_W-1:0]  COLS_RESET = 11'd32;
   localparam logic [WIN_W-1:0]  SIZE_RESET = 2'd2;
   localparam logic [WIN_W-1:0]  STEP_RESET = 2'd2;

   typedef enum logic [1:0] {
      CSR_PLANE_ROWS  = 2'd0,
      CSR_PLANE_COLS  = 2'd1,
      CSR_WINDOW_SIZE = 2'd2,
      CSR_WINDOW_STEP = 2'd3
   } csr_index_type;

endpackage

// ===== rtl/max_pooling_2d_window_top.sv =====
// streaming 2-d max pooling over signed q8.8 planes
// input channel req_valid/req_ready/req_sample: one pixel per transfer, raster
// order within a plane; planes follow each other with no gap
// result channel rsp_valid/rsp_ready/rsp_pooled/rsp_plane_done: one window
// maximum per complete window whose origin sits on the stride grid;
// rsp_plane_done marks the last window of the plane
// csr_write_en/csr_index/csr_data: plane_rows, plane_cols, window_size,
// window_step; any write restarts the plane at row 0, column 0
// throughput: one pixel per cycle while the result side takes results, set by
// the line store that is read at the pixel's column on transfer and rewritten
// there once the pixel moves on; a result is valid once the pixel that completes
// its window has passed the line store read, the column cells and the output register
// when rsp_ready is low with a result waiting, the whole pipe holds and
// req_ready drops in the same cycle; nothing is lost or repeated
// reset: registers return to 32x32 planes, 2x2 windows, stride 2, position
// zero, pipe empty; the line store is not cleared, only rows of the current
// plane ever reach a result
module max_pooling_2d_window_top #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_WINDOW = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mp2w_pkg::sample_type req_sample,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mp2w_pkg::sample_type rsp_pooled,
   output logic                 rsp_plane_done,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [10:0]          csr_data
);

   localparam int LINE_ROWS = MAX_WINDOW - 1;
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int COLS_W    = $clog2(MAX_COLS + 1);
   localparam int SUM_W     = COLS_W + 1;
   localparam int SW        = mp2w_pkg::SAMPLE_W;
   localparam int WORD_W    = LINE_ROWS * SW;

   // configuration
   logic [mp2w_pkg::CSR_W-1:0] rows_cfg_ff;
   logic [mp2w_pkg::CSR_W-1:0] cols_cfg_ff;
   logic [mp2w_pkg::WIN_W-1:0] size_cfg_ff;
   logic [mp2w_pkg::WIN_W-1:0] step_cfg_ff;

   logic [mp2w_pkg::ROWS_W-1:0] rows_eff;
   logic [COLS_W-1:0]           cols_eff;
   logic [mp2w_pkg::WIN_W-1:0]  size_eff;
   logic [mp2w_pkg::WIN_W-1:0]  step_eff;
   logic [31:0]                 cols_raw;

   // position
   logic [mp2w_pkg::ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [1:0]                 row_ph_ff, row_ph_in;
   logic [1:0]                 col_ph_ff, col_ph_in;

   logic [mp2w_pkg::ROWS_W-1:0] row_next1;
   logic [COLS_W-1:0]           col_next1;
   logic [COLS_W-1:0]           size_c;
   logic [mp2w_pkg::ROWS_W-1:0] size_r;
   logic                        col_wrap;
   logic                        emit_a;
   logic                        last_a;

   // pipeline
   logic adv;
   logic accept;
   logic b_valid_ff;
   logic b_emit_ff;
   logic b_last_ff;
   mp2w_pkg::sample_type b_sample_ff;
   logic [COL_W-1:0]     b_addr_ff;
   logic c_valid_ff;
   logic c_emit_ff;
   logic c_last_ff;
   logic rsp_valid_ff;
   mp2w_pkg::sample_type rsp_pooled_ff;
   logic rsp_done_ff;

   logic [WORD_W-1:0]    rd_word;
   logic [WORD_W-1:0]    wr_word;
   mp2w_pkg::sample_type col_max;
   logic                 cell_shift;

   mp2w_pkg::sample_type col_link [MAX_WINDOW+1];
   mp2w_pkg::sample_type run_link [MAX_WINDOW+1];
   logic                 cell_used [MAX_WINDOW];

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   always_comb begin
      cols_raw = 32'(cols_cfg_ff);
      if (rows_cfg_ff == '0) begin
         rows_eff = 11'd1;
      end else if (rows_cfg_ff > mp2w_pkg::ROW_LIMIT) begin
         rows_eff = mp2w_pkg::ROW_LIMIT;
      end else begin
         rows_eff = rows_cfg_ff;
      end
      if (cols_raw == 32'd0) begin
         cols_eff = COLS_W'(1);
      end else if (cols_raw > 32'(MAX_COLS)) begin
         cols_eff = COLS_W'(MAX_COLS);
      end else begin
         cols_eff = COLS_W'(cols_raw);
      end
      if (size_cfg_ff == '0) begin
         size_eff = 2'd1;
      end else if (32'(size_cfg_ff) > 32'(MAX_WINDOW)) begin
         size_eff = 2'(MAX_WINDOW);
      end else begin
         size_eff = size_cfg_ff;
      end
      step_eff = (step_cfg_ff == '0) ? 2'd1 : step_cfg_ff;
   end

   // window detection and position advance
   always_comb begin
      size_c    = COLS_W'(size_eff);
      size_r    = mp2w_pkg::ROWS_W'(size_eff);
      row_next1 = mp2w_pkg::ROWS_W'(row_ff) + 11'd1;
      col_next1 = COLS_W'(col_ff) + COLS_W'(1);
      emit_a    = (row_next1 >= size_r) && (col_next1 >= size_c) &&
                  (size_r <= rows_eff) && (size_c <= cols_eff) &&
                  (row_ph_ff == 2'd0) && (col_ph_ff == 2'd0);
      last_a    = ((mp2w_pkg::ROWS_W'(row_ff) + mp2w_pkg::ROWS_W'(step_eff)) >= rows_eff) &&
                  ((SUM_W'(col_ff) + SUM_W'(step_eff)) >= SUM_W'(cols_eff));
      col_wrap  = col_next1 >= cols_eff;

      col_in    = col_wrap ? '0 : COL_W'(col_next1);
      if (COLS_W'(col_in) < size_c) begin
         col_ph_in = 2'd0;
      end else if (col_ph_ff == (step_eff - 2'd1)) begin
         col_ph_in = 2'd0;
      end else begin
         col_ph_in = col_ph_ff + 2'd1;
      end

      row_in    = row_ff;
      row_ph_in = row_ph_ff;
      if (col_wrap) begin
         row_in = (row_next1 >= rows_eff) ? '0 : row_next1[mp2w_pkg::ROW_W-1:0];
         if (mp2w_pkg::ROWS_W'(row_in) < size_r) begin
            row_ph_in = 2'd0;
         end else if (row_ph_ff == (step_eff - 2'd1)) begin
            row_ph_in = 2'd0;
         end else begin
            row_ph_in = row_ph_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= mp2w_pkg::ROWS_RESET;
         cols_cfg_ff <= mp2w_pkg::COLS_RESET;
         size_cfg_ff <= mp2w_pkg::SIZE_RESET;
         step_cfg_ff <= mp2w_pkg::STEP_RESET;
         row_ff      <= '0;
         col_ff      <= '0;
         row_ph_ff   <= '0;
         col_ph_ff   <= '0;
      end else begin
         priority if (csr_write_en) begin
            unique case (mp2w_pkg::csr_index_type'(csr_index))
               mp2w_pkg::CSR_PLANE_ROWS:  rows_cfg_ff <= csr_data;
               mp2w_pkg::CSR_PLANE_COLS:  cols_cfg_ff <= csr_data;
               mp2w_pkg::CSR_WINDOW_SIZE: size_cfg_ff <= csr_data[1:0];
               mp2w_pkg::CSR_WINDOW_STEP: step_cfg_ff <= csr_data[1:0];
            endcase
            row_ff    <= '0;
            col_ff    <= '0;
            row_ph_ff <= '0;
            col_ph_ff <= '0;
         end else if (accept) begin
            row_ff    <= row_in;
            col_ff    <= col_in;
            row_ph_ff <= row_ph_in;
            col_ph_ff <= col_ph_in;
         end else begin
            row_ff <= row_ff;
         end
      end
   end

   // pipe control
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff   <= accept;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff && c_emit_ff;
      end
   end

   // pipe payload
   always_ff @(posedge clock) begin
      if (adv) begin
         if (accept) begin
            b_sample_ff <= req_sample;
            b_addr_ff   <= col_ff;
            b_emit_ff   <= emit_a;
            b_last_ff   <= last_a;
         end
         c_emit_ff     <= b_emit_ff;
         c_last_ff     <= b_last_ff;
         rsp_pooled_ff <= run_link[MAX_WINDOW];
         rsp_done_ff   <= c_last_ff;
      end
   end

   mp2w_line_mem #(
      .DEPTH (MAX_COLS),
      .WIDTH (WORD_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_word),
      .wr_en   (cell_shift),
      .wr_addr (b_addr_ff),
      .wr_data (wr_word)
   );

   assign cell_shift = adv && b_valid_ff;

   // new column: pixel on top, older rows from the line store
   always_comb begin
      mp2w_pkg::sample_type val;
      col_max = b_sample_ff;
      wr_word = '0;
      wr_word[SW-1:0] = b_sample_ff;
      for (int k = 1; k < MAX_WINDOW; k++) begin
         val = rd_word[(k-1)*SW +: SW];
         if ((k < int'(size_eff)) && (val > col_max)) begin
            col_max = val;
         end
      end
      for (int i = 1; i < LINE_ROWS; i++) begin
         wr_word[i*SW +: SW] = rd_word[(i-1)*SW +: SW];
      end
   end

   assign col_link[0] = col_max;
   assign run_link[0] = mp2w_pkg::SAMPLE_MIN;

   for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
      assign cell_used[j] = j < int'(size_eff);

      mp2w_cell u_cell (
         .clock    (clock),
         .shift    (cell_shift),
         .col_in   (col_link[j]),
         .col_used (cell_used[j]),
         .run_in   (run_link[j]),
         .col_out  (col_link[j+1]),
         .run_out  (run_link[j+1])
      );
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pooled     = rsp_pooled_ff;
   assign rsp_plane_done = rsp_done_ff;

endmodule

// ===== rtl/mp2w_line_mem.sv =====
module mp2w_line_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] line_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_ff[wr_addr] <= wr_data;
      end
   end

   // same-address write in the read cycle is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= line_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mp2w_cell.sv =====
module mp2w_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  mp2w_pkg::sample_type col_in,
   input  logic                 col_used,
   input  mp2w_pkg::sample_type run_in,
   output mp2w_pkg::sample_type col_out,
   output mp2w_pkg::sample_type run_out
);

   mp2w_pkg::sample_type col_ff;

   // column maximum moves one cell on per transfer
   always_ff @(posedge clock) begin
      if (shift) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;
   assign run_out = (col_used && (col_ff > run_in)) ? col_ff : run_in;

endmodule

// ===== sim/tb_max_pooling_2d_window_top.sv =====
module tb_max_pooling_2d_window_top;

   localparam int COLS_MAX        = 1024;
   localparam int DRAIN_CYCLES    = 8;
   localparam int LONG_HOLD       = 300;
   localparam int RANDOM_PIXELS   = 800;
   localparam int unsigned CYCLE_LIMIT = 1000000;

   typedef struct {
      mp2w_pkg::sample_type pooled;
      logic                 plane_done;
   } pool_result_type;

   typedef enum logic [1:0] {
      SCRIPT_CONFIG,
      SCRIPT_PIXEL,
      SCRIPT_KNOWN
   } script_kind_type;

   typedef struct {
      script_kind_type      kind;
      logic [10:0]          rows_word;
      logic [10:0]          cols_word;
      logic [10:0]          size_word;
      logic [10:0]          step_word;
      mp2w_pkg::sample_type pixel;
      logic                 hit;
      pool_result_type      want;
   } script_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   mp2w_pkg::sample_type req_sample = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   mp2w_pkg::sample_type rsp_pooled;
   logic       rsp_plane_done;
   logic       csr_write_en = 1'b0;
   logic [1:0] csr_index = mp2w_pkg::CSR_PLANE_ROWS;
   logic [10:0] csr_data = '0;

   // predictor state
   logic [10:0] rows_reg = mp2w_pkg::ROWS_RESET;
   logic [10:0] cols_reg = mp2w_pkg::COLS_RESET;
   logic [1:0]  size_reg = mp2w_pkg::SIZE_RESET;
   logic [1:0]  step_reg = mp2w_pkg::STEP_RESET;
   mp2w_pkg::sample_type line_rows [2][COLS_MAX];
   mp2w_pkg::sample_type window_cells [3][3];
   int unsigned row_at = 0;
   int unsigned col_at = 0;

   pool_result_type pooled_fifo[$];
   script_row_type  directed_script[$];
   pool_result_type want_now;
   int unsigned     fail_count = 0;
   int unsigned     cycle_count = 0;
   bit              quiet_mode = 1'b0;
   bit              hold_off_req = 1'b0;

   max_pooling_2d_window_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pooled     (rsp_pooled),
      .rsp_plane_done (rsp_plane_done),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned fit(input int unsigned v, input int unsigned lo,
                                       input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic pool_pixel(input mp2w_pkg::sample_type pixel,
                                       output pool_result_type res);
      int unsigned rows, cols, win, stride, r, c, k, j, last_r, last_c;
      int best;
      logic hit;
      rows   = fit(rows_reg, 1, 1024);
      cols   = fit(cols_reg, 1, COLS_MAX);
      win    = fit(size_reg, 1, 3);
      stride = (step_reg == 0) ? 1 : step_reg;
      r = (row_at >= rows) ? 0 : row_at;
      c = (col_at >= cols) ? 0 : col_at;
      hit = 1'b0;
      res.pooled = '0;
      res.plane_done = 1'b0;
      for (k = 0; k < 3; k++)
         for (j = 2; j > 0; j--)
            window_cells[k][j] = window_cells[k][j-1];
      window_cells[0][0] = pixel;
      for (k = 1; k < 3; k++)
         window_cells[k][0] = line_rows[((r % 2) + 2 - (k % 2)) % 2][c];
      line_rows[r % 2][c] = pixel;
      if (r + 1 >= win && c + 1 >= win && win <= rows && win <= cols &&
          (r + 1 - win) % stride == 0 && (c + 1 - win) % stride == 0) begin
         best = -32768;
         last_r = ((rows - win) / stride) * stride + win - 1;
         last_c = ((cols - win) / stride) * stride + win - 1;
         for (k = 0; k < win; k++)
            for (j = 0; j < win; j++)
               if (window_cells[k][j] > best) best = window_cells[k][j];
         res.pooled = mp2w_pkg::sample_type'(best);
         res.plane_done = (r == last_r && c == last_c);
         hit = 1'b1;
      end
      c++;
      if (c >= cols) begin
         c = 0;
         r++;
         if (r >= rows) r = 0;
      end
      row_at = r;
      col_at = c;
      return hit;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic mp2w_pkg::sample_type next_pixel();
      if ($urandom_range(0, 9) != 0) return mp2w_pkg::sample_type'($urandom);
      case ($urandom_range(0, 3))
         0: return mp2w_pkg::SAMPLE_MIN;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         default: return 16'shffff;
      endcase
   endfunction

   function automatic void add_config(input logic [10:0] rows, input logic [10:0] cols,
                                      input logic [10:0] win, input logic [10:0] stride);
      script_row_type row;
      row = '{kind: SCRIPT_CONFIG, default: '0};
      row.kind = SCRIPT_CONFIG;
      row.rows_word = rows;
      row.cols_word = cols;
      row.size_word = win;
      row.step_word = stride;
      directed_script.push_back(row);
   endfunction

   function automatic void add_pixel(input mp2w_pkg::sample_type pixel);
      script_row_type row;
      row = '{kind: SCRIPT_PIXEL, default: '0};
      row.kind = SCRIPT_PIXEL;
      row.pixel = pixel;
      directed_script.push_back(row);
   endfunction

   function automatic void add_known(input mp2w_pkg::sample_type pixel, input logic hit,
                                     input mp2w_pkg::sample_type pooled, input logic done);
      script_row_type row;
      row = '{kind: SCRIPT_KNOWN, default: '0};
      row.kind = SCRIPT_KNOWN;
      row.pixel = pixel;
      row.hit = hit;
      row.want.pooled = pooled;
      row.want.plane_done = done;
      directed_script.push_back(row);
   endfunction

   task automatic settle(input int unsigned drain);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pooled_fifo.size() != 0) @(posedge clock);
      repeat (drain) @(posedge clock);
   endtask

   task automatic load_config(input logic [10:0] rows, input logic [10:0] cols,
                              input logic [10:0] win, input logic [10:0] stride);
      settle(DRAIN_CYCLES);
      csr_write_en <= 1'b1;
      csr_index    <= mp2w_pkg::CSR_PLANE_ROWS;
      csr_data     <= rows;
      @(posedge clock);
      csr_index    <= mp2w_pkg::CSR_PLANE_COLS;
      csr_data     <= cols;
      @(posedge clock);
      csr_index    <= mp2w_pkg::CSR_WINDOW_SIZE;
      csr_data     <= win;
      @(posedge clock);
      csr_index    <= mp2w_pkg::CSR_WINDOW_STEP;
      csr_data     <= stride;
      @(posedge clock);
      csr_write_en <= 1'b0;
      rows_reg = rows;
      cols_reg = cols;
      size_reg = win[1:0];
      step_reg = stride[1:0];
      row_at = 0;
      col_at = 0;
   endtask

   task automatic send_pixel(input script_row_type row);
      int unsigned gap;
      pool_result_type res;
      logic hit;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= row.pixel;
      do @(posedge clock); while (!req_ready);
      hit = pool_pixel(row.pixel, res);
      if (row.kind == SCRIPT_KNOWN) begin
         hit = row.hit;
         res = row.want;
      end
      if (hit) pooled_fifo.push_back(res);
   endtask

   // result side: random back-pressure plus one long hold on request
   initial begin : result_sink
      int unsigned gap;
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_req = 1'b0;
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pooled_fifo.size() == 0) begin
            $error("rsp_pooled: no result expected, got %h", rsp_pooled);
            fail_count++;
         end else begin
            want_now = pooled_fifo.pop_front();
            if (rsp_pooled !== want_now.pooled) begin
               $error("rsp_pooled: expected %h, got %h", want_now.pooled, rsp_pooled);
               fail_count++;
            end
            if (rsp_plane_done !== want_now.plane_done) begin
               $error("rsp_plane_done: expected %b, got %b", want_now.plane_done,
                      rsp_plane_done);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      script_row_type row;
      int unsigned random_pixels, roll, plane, n;
      logic [10:0] rows_word, cols_word, size_word, step_word;
      random_pixels = 0;
      for (int i = 0; i < 2; i++)
         for (int k = 0; k < COLS_MAX; k++)
            line_rows[i][k] = '0;
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            window_cells[i][k] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset setting: 2x2 windows cannot close on row zero
      add_known(16'sh1234, 1'b0, '0, 1'b0);
      add_known(mp2w_pkg::SAMPLE_MIN, 1'b0, '0, 1'b0);
      // zero sizes count as one: every pixel is its own plane and window
      add_config(11'd0, 11'd0, 11'd1, 11'd0);
      add_known(16'sh7fff, 1'b1, 16'sh7fff, 1'b1);
      add_known(mp2w_pkg::SAMPLE_MIN, 1'b1, mp2w_pkg::SAMPLE_MIN, 1'b1);
      add_known(16'sh0000, 1'b1, 16'sh0000, 1'b1);
      add_known(16'shffff, 1'b1, 16'shffff, 1'b1);
      add_config(11'd0, 11'd0, 11'd0, 11'd1);
      add_known(16'sh0100, 1'b1, 16'sh0100, 1'b1);
      // window larger than plane
      add_config(11'd1, 11'd1, 11'd2, 11'd1);
      add_known(16'sh4000, 1'b0, '0, 1'b0);
      // all-minimum window, then a single maximum
      add_config(11'd2, 11'd2, 11'd2, 11'd1);
      add_known(mp2w_pkg::SAMPLE_MIN, 1'b0, '0, 1'b0);
      add_known(mp2w_pkg::SAMPLE_MIN, 1'b0, '0, 1'b0);
      add_known(mp2w_pkg::SAMPLE_MIN, 1'b0, '0, 1'b0);
      add_known(mp2w_pkg::SAMPLE_MIN, 1'b1, mp2w_pkg::SAMPLE_MIN, 1'b1);
      add_known(mp2w_pkg::SAMPLE_MIN, 1'b0, '0, 1'b0);
      add_known(16'sh7fff, 1'b0, '0, 1'b0);
      add_known(mp2w_pkg::SAMPLE_MIN, 1'b0, '0, 1'b0);
      add_known(mp2w_pkg::SAMPLE_MIN, 1'b1, 16'sh7fff, 1'b1);
      // largest window and stride
      add_config(11'd3, 11'd3, 11'd3, 11'd3);
      add_pixel(16'sh0001);
      add_pixel(16'shff00);
      add_pixel(16'sh0080);
      add_pixel(16'sh7ffe);
      add_pixel(16'sh8001);
      add_pixel(16'sh0000);
      add_pixel(16'sh0101);
      add_pixel(16'shffff);
      add_pixel(16'sh00ff);

      foreach (directed_script[i]) begin
         if (directed_script[i].kind == SCRIPT_CONFIG)
            load_config(directed_script[i].rows_word, directed_script[i].cols_word,
                        directed_script[i].size_word, directed_script[i].step_word);
         else
            send_pixel(directed_script[i]);
      end

      // widest row with the result side held off for a while
      load_config(11'd1, 11'd2047, 11'd1, 11'd3);
      quiet_mode = 1'b0;
      hold_off_req = 1'b1;
      row = '{kind: SCRIPT_PIXEL, default: '0};
      row.kind = SCRIPT_PIXEL;
      repeat (COLS_MAX) begin
         row.pixel = next_pixel();
         send_pixel(row);
      end

      while (random_pixels < RANDOM_PIXELS) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) rows_word = 11'd0;
         else if (roll < 10) rows_word = 11'($urandom_range(1024, 2047));
         else rows_word = 11'($urandom_range(1, 6));
         roll = $urandom_range(0, 99);
         if (roll < 5) cols_word = 11'd0;
         else if (roll < 8) cols_word = 11'($urandom_range(1024, 2047));
         else cols_word = 11'($urandom_range(1, 8));
         size_word = {9'($urandom), 2'($urandom_range(0, 3))};
         step_word = {9'($urandom), 2'($urandom_range(0, 3))};
         load_config(rows_word, cols_word, size_word, step_word);
         quiet_mode = ($urandom_range(0, 4) == 0);
         plane = fit(rows_word, 1, 1024) * fit(cols_word, 1, COLS_MAX);
         n = plane * $urandom_range(1, 3) + $urandom_range(0, plane - 1);
         if (n > 200) n = $urandom_range(40, 200);
         repeat (n) begin
            if ($urandom_range(0, 299) == 0) settle(0);
            row.pixel = next_pixel();
            send_pixel(row);
            random_pixels++;
         end
      end

      settle(DRAIN_CYCLES);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mp2w_pkg.sv
rtl/mp2w_line_mem.sv
rtl/mp2w_cell.sv
rtl/max_pooling_2d_window_top.sv
sim/tb_max_pooling_2d_window_top.sv
